@@ src/lpr_pkg.sv @@
// Shared constants and types for the line point rasterizer.
// No dependencies; imported by lpr_div, line_point_rasterizer_core and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  // Coordinate width default for the top-level parameter
  localparam int COORD_BITS_DEF = 13;

  // Fixed field widths
  localparam int IDX_W   = 13;
  localparam int COLOR_W = 24;
  localparam int OUT_W   = 12;
  localparam int CFG_W   = 13;
  localparam int STEP_W  = 5;
  localparam int OUT_DATA_W = 2 * OUT_W + COLOR_W;

  // Largest value an output coordinate can hold
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // APB register file
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_STEP   = 2'd2;

  localparam logic [CFG_W-1:0]  WIDTH_RST  = 13'd2000;
  localparam logic [CFG_W-1:0]  HEIGHT_RST = 13'd1000;
  localparam logic [STEP_W-1:0] STEP_RST   = 5'd3;

endpackage

`default_nettype wire

@@ src/lpr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Uses lpr_pkg; instantiated by line_point_rasterizer_core.
`timescale 1ns / 1ps
`default_nettype none

module lpr_div
  import lpr_pkg::*;
#(
  parameter int NW = 2 * COORD_BITS_DEF + 2,  // dividend magnitude width
  parameter int DW = COORD_BITS_DEF + 1,      // divisor width
  parameter int QB = COORD_BITS_DEF + 1,      // quotient bits produced
  parameter int SW = 8                        // sideband width
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] mag_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QB-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  // Caller guarantees mag_i < den_i * 2**QB, so the upper dividend bits
  // already sit below the divisor and form the starting remainder.
  logic          vld_q  [QB];
  logic [DW-1:0] rem_q  [QB];
  logic [QB-1:0] bits_q [QB];  // low dividend bits shift out, quotient bits shift in
  logic [DW-1:0] den_q  [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QB-1:0] bits_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = mag_i[NW-1:QB];
      assign bits_in = mag_i[QB-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign bits_in = bits_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, bits_in[QB-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        bits_q[i] <= {bits_in[QB-2:0], ge};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quo_o   = bits_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

`default_nettype wire

@@ src/line_point_rasterizer_core.sv @@
// Top level of the line point rasterizer: APB registers, stream ports, pipeline.
// Uses lpr_pkg and lpr_div.
`timescale 1ns / 1ps
`default_nettype none

// Computes one point of an interpolated line per input item: major axis pick,
// endpoint ordering, major coordinate start + k*step, minor coordinate by
// interpolation with a truncating divide, then clamping to the window. Fully
// pipelined: one item per clock while the output does not stall, through a
// restoring divider that resolves one quotient bit per stage. A stall on the
// output freezes the whole pipeline. Points past the end of the line come out
// with tuser (point_valid) low and all other fields zero.

module line_point_rasterizer_core
  import lpr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // tdata: start_x, start_y, end_x, end_y, line_color, point_index (low bit up)
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [((4*COORD_BITS+COLOR_W+IDX_W+7)/8)*8-1:0] s_axis_tdata,

  // tdata: pixel_x, pixel_y, pixel_color (low bit up); tuser: point_valid;
  // tlast: point_last
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 2;   // product / numerator width
  localparam int DW = CB + 1;       // span + 1 width
  localparam int QB = CB + 1;       // quotient bits
  localparam int MW = CB + 20;      // s + k*step without overflow
  localparam int KS_W = IDX_W + STEP_W;
  localparam int CW = ((CB > CFG_W) ? CB : CFG_W) + 2;

  // ---------------------------------------------------------------- registers
  logic [CFG_W-1:0]  window_width_q, window_height_q;
  logic [STEP_W-1:0] pixel_step_q;
  logic              cfg_wr;
  logic [STEP_W-1:0] step_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_width_q  <= WIDTH_RST;
      window_height_q <= HEIGHT_RST;
      pixel_step_q    <= STEP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  window_width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: window_height_q <= pwdata[CFG_W-1:0];
        REG_STEP:   pixel_step_q    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = APB_DW'(window_width_q);
      REG_HEIGHT: prdata = APB_DW'(window_height_q);
      REG_STEP:   prdata = APB_DW'(pixel_step_q);
      default:    prdata = '0;
    endcase
  end

  // zero step behaves as one
  assign step_eff = (pixel_step_q == '0) ? STEP_W'(1) : pixel_step_q;

  // ---------------------------------------------------------------- control
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- stage A
  // axis pick and endpoint ordering
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic [COLOR_W-1:0]   in_color;
  logic [IDX_W-1:0]     in_idx;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          adx, ady;
  logic                 xmaj;
  logic signed [CB-1:0] s0, e0, a0, b0;
  logic                 swap;

  assign x0       = s_axis_tdata[CB-1:0];
  assign y0       = s_axis_tdata[2*CB-1:CB];
  assign x1       = s_axis_tdata[3*CB-1:2*CB];
  assign y1       = s_axis_tdata[4*CB-1:3*CB];
  assign in_color = s_axis_tdata[4*CB+COLOR_W-1:4*CB];
  assign in_idx   = s_axis_tdata[4*CB+COLOR_W+IDX_W-1:4*CB+COLOR_W];

  assign dx   = {x0[CB-1], x0} - {x1[CB-1], x1};
  assign dy   = {y0[CB-1], y0} - {y1[CB-1], y1};
  assign adx  = dx[CB] ? DW'(-dx) : DW'(dx);
  assign ady  = dy[CB] ? DW'(-dy) : DW'(dy);
  assign xmaj = adx >= ady;
  assign s0   = xmaj ? x0 : y0;
  assign e0   = xmaj ? x1 : y1;
  assign a0   = xmaj ? y0 : x0;
  assign b0   = xmaj ? y1 : x1;
  assign swap = s0 > e0;

  logic                 a_vld_q;
  logic signed [CB-1:0] a_s_q, a_e_q, a_a_q, a_b_q;
  logic                 a_xmaj_q;
  logic [COLOR_W-1:0]   a_color_q;
  logic [IDX_W-1:0]     a_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_s_q     <= swap ? e0 : s0;
      a_e_q     <= swap ? s0 : e0;
      a_a_q     <= swap ? b0 : a0;
      a_b_q     <= swap ? a0 : b0;
      a_xmaj_q  <= xmaj;
      a_color_q <= in_color;
      a_idx_q   <= in_idx;
    end
  end

  // ---------------------------------------------------------------- stage B
  // major coordinate and range checks
  logic [KS_W-1:0]      kstep;
  logic signed [MW-1:0] m_full, e_full;
  logic                 pt_valid, pt_last;

  assign kstep    = KS_W'(a_idx_q) * KS_W'(step_eff);
  assign m_full   = MW'(a_s_q) + $signed(MW'(kstep));
  assign e_full   = MW'(a_e_q);
  assign pt_valid = m_full <= e_full;
  assign pt_last  = (m_full + $signed(MW'(step_eff))) > e_full;

  logic                 b_vld_q;
  logic signed [CB-1:0] b_m_q, b_s_q, b_e_q, b_a_q, b_b_q;
  logic                 b_xmaj_q, b_pv_q, b_pl_q;
  logic [COLOR_W-1:0]   b_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_m_q     <= m_full[CB-1:0];
      b_s_q     <= a_s_q;
      b_e_q     <= a_e_q;
      b_a_q     <= a_a_q;
      b_b_q     <= a_b_q;
      b_xmaj_q  <= a_xmaj_q;
      b_pv_q    <= pt_valid;
      b_pl_q    <= pt_valid & pt_last;
      b_color_q <= a_color_q;
    end
  end

  // ---------------------------------------------------------------- stage C
  // interpolation weights and products
  logic signed [CB:0]   m_x, s_x, e_x;
  logic [DW-1:0]        d1, d2, den;
  logic signed [PW-1:0] p1, p2;

  assign m_x = {b_m_q[CB-1], b_m_q};
  assign s_x = {b_s_q[CB-1], b_s_q};
  assign e_x = {b_e_q[CB-1], b_e_q};
  assign d1  = e_x - m_x;
  assign d2  = m_x - s_x + DW'(1);
  assign den = e_x - s_x + DW'(1);
  assign p1  = b_a_q * $signed({1'b0, d1});
  assign p2  = b_b_q * $signed({1'b0, d2});

  logic                 c_vld_q;
  logic signed [PW-1:0] c_p1_q, c_p2_q;
  logic [DW-1:0]        c_den_q;
  logic signed [CB-1:0] c_m_q;
  logic                 c_xmaj_q, c_pv_q, c_pl_q;
  logic [COLOR_W-1:0]   c_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_p1_q    <= p1;
      c_p2_q    <= p2;
      c_den_q   <= den;
      c_m_q     <= b_m_q;
      c_xmaj_q  <= b_xmaj_q;
      c_pv_q    <= b_pv_q;
      c_pl_q    <= b_pl_q;
      c_color_q <= b_color_q;
    end
  end

  // ---------------------------------------------------------------- stage D
  // numerator sign and magnitude for the divider
  typedef struct packed {
    logic                 neg;
    logic                 xmaj;
    logic                 pv;
    logic                 pl;
    logic signed [CB-1:0] m;
    logic [COLOR_W-1:0]   color;
  } side_t;

  logic signed [PW-1:0] num;

  assign num = c_p1_q + c_p2_q;

  logic          d_vld_q;
  logic [PW-1:0] d_mag_q;
  logic [DW-1:0] d_den_q;
  side_t         d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_mag_q        <= num[PW-1] ? PW'(-num) : PW'(num);
      d_den_q        <= c_den_q;
      d_side_q.neg   <= num[PW-1];
      d_side_q.xmaj  <= c_xmaj_q;
      d_side_q.pv    <= c_pv_q;
      d_side_q.pl    <= c_pl_q;
      d_side_q.m     <= c_m_q;
      d_side_q.color <= c_color_q;
    end
  end

  // ---------------------------------------------------------------- divider
  logic                    q_vld;
  logic [QB-1:0]           q_mag;
  logic [$bits(side_t)-1:0] q_side_raw;
  side_t                   q_side;

  lpr_div #(
    .NW (PW),
    .DW (DW),
    .QB (QB),
    .SW ($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .mag_i   (d_mag_q),
    .den_i   (d_den_q),
    .side_i  (d_side_q),
    .valid_o (q_vld),
    .quo_o   (q_mag),
    .side_o  (q_side_raw)
  );

  assign q_side = side_t'(q_side_raw);

  // ---------------------------------------------------------------- output
  function automatic logic [OUT_W-1:0] clamp_coord(logic signed [CB-1:0] v,
                                                   logic [CFG_W-1:0] size);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] top;
    r   = CW'(v);
    hi  = $signed(CW'(size)) - $signed(CW'(1));
    top = $signed(CW'(OUT_MAX));
    if (r > hi) r = hi;
    if (r[CW-1]) r = '0;
    if (r > top) r = top;
    return r[OUT_W-1:0];
  endfunction

  logic signed [CB+1:0] minor_full;
  logic signed [CB-1:0] minor, px, py;

  assign minor_full = q_side.neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign minor      = minor_full[CB-1:0];
  assign px         = q_side.xmaj ? q_side.m : minor;
  assign py         = q_side.xmaj ? minor : q_side.m;

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (q_side.pv) begin
        out_data_q <= {q_side.color, clamp_coord(py, window_height_q),
                       clamp_coord(px, window_width_q)};
      end else begin
        out_data_q <= '0;
      end
      out_user_q <= q_side.pv;
      out_last_q <= q_side.pl;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ sim/tb_line_point_rasterizer_core.sv @@
// Self-checking testbench for line_point_rasterizer_core: streams line point
// requests, predicts every point in a scoreboard class and compares each output item.
// Depends on lpr_pkg and the RTL of the core; nothing else.
`timescale 1ns / 1ps

module tb_line_point_rasterizer_core;
  import lpr_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int IN_BITS   = 4 * CB + COLOR_W + IDX_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int DRAIN_CYCLES   = CB + 6 + 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 6;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey;
    logic [COLOR_W-1:0]   color;
    logic [IDX_W-1:0]     k;
  } line_req_t;

  typedef struct {
    logic [OUT_W-1:0]   px, py;
    logic [COLOR_W-1:0] color;
    logic               valid, last;
  } point_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_RARE} rx_mode_e;

  class lpr_scoreboard;
    logic [CFG_W-1:0]  width  = WIDTH_RST;
    logic [CFG_W-1:0]  height = HEIGHT_RST;
    logic [STEP_W-1:0] step   = STEP_RST;
    point_t            point_q[$];
    int                errors = 0;

    function logic [OUT_W-1:0] clamp(longint v, longint size);
      longint hi;
      hi = size - 1;
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
      return v[OUT_W-1:0];
    endfunction

    function point_t predict(line_req_t r);
      longint x0, y0, x1, y1, s, e, a, b, t, m, stp, mn, px, py;
      bit     x_major;
      point_t p;
      p = '{default: '0};
      x0 = r.sx;
      y0 = r.sy;
      x1 = r.ex;
      y1 = r.ey;
      stp = (step == 0) ? 1 : longint'(step);
      x_major = ((x0 > x1) ? x0 - x1 : x1 - x0) >= ((y0 > y1) ? y0 - y1 : y1 - y0);
      if (x_major) begin
        s = x0; e = x1; a = y0; b = y1;
      end else begin
        s = y0; e = y1; a = x0; b = x1;
      end
      if (s > e) begin
        t = s; s = e; e = t;
        t = a; a = b; b = t;
      end
      m = s + longint'(r.k) * stp;
      if (m > e) return p;
      // signed longint division truncates toward zero
      mn = (a * (e - m) + b * (m - s + 1)) / (e - s + 1);
      px = x_major ? m : mn;
      py = x_major ? mn : m;
      p.px    = clamp(px, longint'(width));
      p.py    = clamp(py, longint'(height));
      p.color = r.color;
      p.valid = 1'b1;
      p.last  = (m + stp > e);
      return p;
    endfunction

    function void note_line(line_req_t r);
      point_q.insert(point_q.size(), predict(r));
    endfunction

    function void check_point(point_t got);
      point_t exp;
      if (point_q.size() == 0) begin
        $error("unexpected output item x=%0d y=%0d", got.px, got.py);
        errors++;
        return;
      end
      exp = point_q.pop_front();
      if (got.px !== exp.px) begin
        $error("pixel_x expected %0d got %0d", exp.px, got.px);
        errors++;
      end
      if (got.py !== exp.py) begin
        $error("pixel_y expected %0d got %0d", exp.py, got.py);
        errors++;
      end
      if (got.color !== exp.color) begin
        $error("pixel_color expected %06h got %06h", exp.color, got.color);
        errors++;
      end
      if (got.valid !== exp.valid) begin
        $error("point_valid expected %0b got %0b", exp.valid, got.valid);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("point_last expected %0b got %0b", exp.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return point_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  lpr_scoreboard sb;
  rx_mode_e      rx_mode = RX_ALWAYS;
  int            hold_left = 0;
  int            rx_cnt = 0;
  int            burst_left = 0;
  bit            tx_gaps = 1'b0;
  int            stuck = 0;

  line_point_rasterizer_core #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Output side: check accepted items, then pick tready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_point('{px: m_axis_tdata[OUT_W-1:0],
                       py: m_axis_tdata[2*OUT_W-1:OUT_W],
                       color: m_axis_tdata[OUT_DATA_W-1:2*OUT_W],
                       valid: m_axis_tuser, last: m_axis_tlast});
    end
    rx_cnt <= rx_cnt + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 9) < 6);
        RX_PATTERN: m_axis_tready <= ((rx_cnt % 11) < 7);
        default:    m_axis_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("tb_line_point_rasterizer_core NOT OK");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  sb.width  = val[CFG_W-1:0];
      REG_HEIGHT: sb.height = val[CFG_W-1:0];
      default:    sb.step   = val[STEP_W-1:0];
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_line(input line_req_t r);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tdata  <= IN_DATA_W'({r.k, r.color, r.ey, r.ex, r.sy, r.sx});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_line(r);
  endtask

  task automatic send_dir(input int sx, input int sy, input int ex, input int ey,
                          input logic [COLOR_W-1:0] color, input int k);
    line_req_t r;
    r.sx = CB'(sx);
    r.sy = CB'(sy);
    r.ex = CB'(ex);
    r.ey = CB'(ey);
    r.color = color;
    r.k = IDX_W'(k);
    send_line(r);
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(CB-1){1'b0}}};
      1:       return {1'b0, {(CB-1){1'b1}}};
      default: return CB'($urandom());
    endcase
  endfunction

  function automatic logic signed [CB-1:0] clip_coord(int v);
    if (v > 2 ** (CB - 1) - 1) return CB'(2 ** (CB - 1) - 1);
    if (v < -(2 ** (CB - 1))) return CB'(-(2 ** (CB - 1)));
    return CB'(v);
  endfunction

  // Mostly whole walks along short lines (k = 0 up to one past the end),
  // mixed with lone requests on arbitrary lines.
  task automatic send_random(input int budget);
    int        sent;
    int        dx, dy, span, stp, k_end;
    line_req_t r;
    sent = 0;
    while (sent < budget) begin
      r.color = COLOR_W'($urandom());
      r.sx = rand_coord();
      r.sy = rand_coord();
      if ($urandom_range(0, 9) < 7) begin
        r.ex = clip_coord(int'(r.sx) + int'($urandom_range(0, 80)) - 40);
        r.ey = clip_coord(int'(r.sy) + int'($urandom_range(0, 80)) - 40);
        dx = int'(r.ex) - int'(r.sx);
        dy = int'(r.ey) - int'(r.sy);
        span = (dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
        stp = (sb.step == 0) ? 1 : int'(sb.step);
        k_end = span / stp + 1;
        for (int k = 0; k <= k_end; k++) begin
          r.k = IDX_W'(k);
          send_line(r);
          sent++;
        end
      end else begin
        r.ex = rand_coord();
        r.ey = rand_coord();
        r.k = IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 2 ** IDX_W - 1)
                                          : $urandom_range(0, 8));
        send_line(r);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned cfg_w[PHASES];
    int unsigned cfg_h[PHASES];
    int unsigned cfg_s[PHASES];
    cfg_w = '{1, 0, 4096, 8191, 640, 0};
    cfg_h = '{1, 0, 4096, 8191, 480, 0};
    cfg_s = '{1, 0, 16, 31, 2, 0};
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset settings (2000 x 1000, step 3).
    send_dir(5, 5, 5, 5, 24'hFFFFFF, 0);              // single-point line
    send_dir(5, 5, 5, 5, 24'h000000, 1);
    send_dir(0, 10, 9, 10, 24'h123456, 0);            // horizontal walk
    send_dir(0, 10, 9, 10, 24'h123456, 1);
    send_dir(0, 10, 9, 10, 24'h123456, 3);            // last point
    send_dir(0, 10, 9, 10, 24'h123456, 4);            // past the end
    send_dir(7, 20, 7, 2, 24'hABCDEF, 0);             // vertical, reversed
    send_dir(7, 20, 7, 2, 24'hABCDEF, 6);
    send_dir(0, 0, 30, -30, 24'h00FF00, 2);           // tie goes to x
    send_dir(-4096, -4096, 4095, 4095, 24'h800001, 0);
    send_dir(-4096, -4096, 4095, 4095, 24'h7FFFFE, 2730);
    send_dir(4095, 4095, -4096, -4096, 24'h555555, 2731);
    send_dir(-4096, 4095, 4095, -4096, 24'hAAAAAA, 8191);
    send_dir(0, -5, 10, 3, 24'h0F0F0F, 1);            // negative minor
    send_dir(0, 5, 10, -3, 24'hF0F0F0, 3);
    send_dir(3000, 0, 3005, 900, 24'h112233, 100);    // x clamps to width
    send_dir(-20, 4000, 1900, 4095, 24'h445566, 5);   // y clamps to height
    send_dir(4095, 0, -4096, 1, 24'h778899, 8191);
    send_dir(-3, -7, 3, -1, 24'hCAFE00, 1);
    s_axis_tvalid <= 1'b0;
    drain();

    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    send_random(150);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == PHASES - 1) begin
        cfg_w[ph] = $urandom_range(0, 2 ** CFG_W - 1);
        cfg_h[ph] = $urandom_range(0, 2 ** CFG_W - 1);
        cfg_s[ph] = $urandom_range(0, 2 ** STEP_W - 1);
      end
      apb_write(REG_WIDTH, cfg_w[ph]);
      apb_write(REG_HEIGHT, cfg_h[ph]);
      apb_write(REG_STEP, cfg_s[ph]);
      rx_mode = rx_mode_e'(ph % 4);
      tx_gaps = (ph != 2);
      // Hold the output off long enough to back the pipeline up to the input.
      if (ph == 1) hold_left = 300;
      send_random(125);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_line_point_rasterizer_core OK");
    end else begin
      $display("tb_line_point_rasterizer_core NOT OK");
    end
    $finish;
  end

endmodule
